FILE: hw/rtl/bus_bandwidth_vote_governor_unit_assert.svh
`ifndef BUS_BANDWIDTH_VOTE_GOVERNOR_UNIT_ASSERT_SVH
`define BUS_BANDWIDTH_VOTE_GOVERNOR_UNIT_ASSERT_SVH

// check a consequent in the same cycle as its antecedent
`define BBVG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check a consequent in the cycle after its antecedent
`define BBVG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/bbvg_pkg.sv
package bbvg_pkg;

    localparam int BUS_LEVELS  = 8;
    localparam int FREQ_LEVELS = 16;

    localparam logic [31:0] FLOOR_TIME   = 32'd50000;
    localparam logic [6:0]  WAIT_LIMIT   = 7'd10;
    localparam logic [6:0]  BUSY_LIMIT   = 7'd75;
    localparam logic [16:0] AB_MAX_RESET = 17'd300;
    localparam logic [19:0] MEGA         = 20'd1000000;
    localparam logic [7:0]  STEP_MB      = 8'd160;
    localparam logic [6:0]  HUNDRED      = 7'd100;

    // ceil(2^22 / 5): exact floor division by 5 for operands below 2^22
    localparam logic [19:0] RECIP_5       = 20'd838861;
    localparam int          RECIP_5_SHIFT = 22;

    typedef enum logic {
        CMD_SAMPLE  = 1'b0,
        CMD_SUSPEND = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        REG_UP_PCT    = 3'd0,
        REG_DOWN_PCT  = 3'd1,
        REG_LEVEL_MAP = 3'd2,
        REG_LEVEL_CNT = 3'd3,
        REG_BUS_WIDTH = 3'd4,
        REG_INIT_WM   = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        HINT_NONE = 2'd0,
        HINT_FAST = 2'd1,
        HINT_SLOW = 2'd2
    } hint_t;

    typedef enum logic {
        JOB_SKIP   = 1'b0,
        JOB_DECIDE = 1'b1
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [31:0] total;
        logic [31:0] busy;
        logic [31:0] ram;
        logic [31:0] wait_cyc;
        logic [3:0]  flev;
        logic [3:0]  offset;
    } job_t;

    typedef struct packed {
        logic        start;
        logic [39:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [39:0] quo;
    } div_rsp_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_RATE,
        B_CHECK,
        B_CYC,
        B_WAIT,
        B_BUSY,
        B_UP,
        B_DOWN,
        B_HINT,
        B_VOTE,
        B_MUL1,
        B_MUL2,
        B_MB,
        B_PCT,
        B_OUT
    } back_state_t;

endpackage

FILE: hw/rtl/bbvg_front.sv
module bbvg_front
    import bbvg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         command,
    input  logic [135:0] fields,
    input  logic         q_full,
    output logic         q_push,
    output job_t         q_job
);

    logic [31:0] acc_total_reg, acc_busy_reg, acc_ram_reg, acc_wait_reg;
    logic [31:0] acc_total_next, acc_busy_next, acc_ram_next, acc_wait_next;
    logic [31:0] sum_total, sum_busy, sum_ram, sum_wait;
    logic [3:0]  flev_in;
    logic [3:0]  flev_clamped;
    logic        accept;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign sum_total = sat_add(acc_total_reg, fields[31:0]);
    assign sum_busy  = sat_add(acc_busy_reg, fields[63:32]);
    assign sum_ram   = sat_add(acc_ram_reg, fields[95:64]);
    assign sum_wait  = sat_add(acc_wait_reg, fields[127:96]);
    assign flev_in   = fields[131:128];
    assign flev_clamped = ({1'b0, flev_in} >= 5'(FREQ_LEVELS)) ? 4'(FREQ_LEVELS - 1) : flev_in;

    always_comb
    begin
        acc_total_next = acc_total_reg;
        acc_busy_next  = acc_busy_reg;
        acc_ram_next   = acc_ram_reg;
        acc_wait_next  = acc_wait_reg;
        q_push         = 1'b0;
        q_job.kind     = JOB_SKIP;
        q_job.total    = sum_total;
        q_job.busy     = sum_busy;
        q_job.ram      = sum_ram;
        q_job.wait_cyc = sum_wait;
        q_job.flev     = flev_clamped;
        q_job.offset   = fields[135:132];
        if (accept)
        begin
            q_push = 1'b1;
            if (cmd_t'(command) == CMD_SUSPEND)
            begin
                acc_total_next = '0;
                acc_busy_next  = '0;
                acc_ram_next   = '0;
            end
            else if (sum_total < FLOOR_TIME)
            begin
                acc_total_next = sum_total;
                acc_busy_next  = sum_busy;
                acc_ram_next   = sum_ram;
                acc_wait_next  = sum_wait;
            end
            else
            begin
                // hand the full window to the back end and restart
                q_job.kind     = JOB_DECIDE;
                acc_total_next = '0;
                acc_busy_next  = '0;
                acc_ram_next   = '0;
                acc_wait_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_total_reg <= '0;
            acc_busy_reg  <= '0;
            acc_ram_reg   <= '0;
            acc_wait_reg  <= '0;
        end
        else
        begin
            acc_total_reg <= acc_total_next;
            acc_busy_reg  <= acc_busy_next;
            acc_ram_reg   <= acc_ram_next;
            acc_wait_reg  <= acc_wait_next;
        end
    end

endmodule

FILE: hw/rtl/bbvg_queue.sv
module bbvg_queue
    import bbvg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic nonempty,
    output job_t head
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign nonempty = (cnt_reg != 2'd0);
    assign head     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: hw/rtl/bbvg_div.sv
module bbvg_div
    import bbvg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [39:0] num_reg, num_next;
    logic [31:0] den_reg, den_next;
    logic [31:0] rem_reg, rem_next;
    logic [39:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic        fits;

    assign trial = {rem_reg, num_reg[39]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            // one restoring step per cycle
            rem_next = fits ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
            quo_next = {quo_reg[38:0], fits};
            num_next = {num_reg[38:0], 1'b0};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd39)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

FILE: hw/rtl/bbvg_back.sv
`include "bus_bandwidth_vote_governor_unit_assert.svh"

module bbvg_back
    import bbvg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        q_nonempty,
    input  job_t        q_head,
    output logic        q_pop,
    output div_req_t    div_req,
    input  div_rsp_t    div_rsp,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_flags,
    output logic [39:0] out_data
);

    back_state_t state_reg, state_next;

    logic [63:0] up_pct_reg, down_pct_reg, map_reg;
    logic [3:0]  count_reg;
    logic [7:0]  bw_reg;
    logic [16:0] wm_reg, wm_next;
    logic [16:0] abmax_reg, abmax_next;

    logic [16:0] rate_reg;
    logic [17:0] cyc_reg;
    logic        wait_hi_reg, busy_hi_reg;
    // cutoff percent times watermark, still to be divided by 100
    logic [24:0] up_cut_reg, down_cut_reg;
    logic [1:0]  hint_reg;
    logic [24:0] prod_reg;
    logic [24:0] mb_reg;
    logic [17:0] abq_reg;
    logic [6:0]  pct_reg;
    logic        pend_reg;

    logic        out_valid_reg;
    logic [2:0]  out_flags_reg;
    logic [39:0] out_data_reg;

    logic        div_state;
    logic        out_load;
    logic [32:0] ram_plus_wait;
    logic [44:0] mb_full;
    logic [20:0] cyc_scaled;
    logic [27:0] cyc_x100;
    logic [25:0] mb_up;
    logic [40:0] mb_div;
    logic [3:0]  map_nib;
    logic signed [5:0] lvl_raw;
    logic [3:0]  lvl_cnt;
    logic [2:0]  lvl;
    logic [7:0]  up_pct, down_pct;
    logic [1:0]  hint_calc;
    logic [24:0] ab_mb;
    logic        ab_valid;
    logic        pct_valid;
    logic [43:0] ab_full;

    assign ram_plus_wait = {1'b0, q_head.ram} + {1'b0, q_head.wait_cyc};
    assign mb_full       = 45'(prod_reg) * 45'(MEGA);
    assign cyc_scaled    = 21'(({3'b0, cyc_reg} * 21'd5) >> 2);
    assign cyc_x100      = 28'(cyc_scaled) * 28'(HUNDRED);
    // round up to the step: divide by 32 with a shift, then by 5 with a reciprocal
    assign mb_up         = 26'(mb_reg) + 26'(STEP_MB - 8'd1);
    assign mb_div        = 41'(mb_up[25:5]) * 41'(RECIP_5);

    // bus level from the map, shifted by the signed offset and clamped
    always_comb
    begin
        map_nib = map_reg[q_head.flev * 4 +: 4];
        lvl_raw = $signed({2'b00, map_nib}) + 6'(signed'(q_head.offset));
        if (count_reg == 4'd0)
        begin
            lvl_cnt = 4'd1;
        end
        else if (count_reg > 4'(BUS_LEVELS))
        begin
            lvl_cnt = 4'(BUS_LEVELS);
        end
        else
        begin
            lvl_cnt = count_reg;
        end
        if (lvl_raw < 0)
        begin
            lvl = '0;
        end
        else if (lvl_raw >= $signed({2'b00, lvl_cnt}))
        begin
            lvl = 3'(lvl_cnt - 4'd1);
        end
        else
        begin
            lvl = lvl_raw[2:0];
        end
        up_pct   = up_pct_reg[lvl * 8 +: 8];
        down_pct = down_pct_reg[lvl * 8 +: 8];
    end

    // cycles > floor(P/100) is P < 100*cycles; cycles < floor(P/100) is 100*(cycles+1) <= P
    always_comb
    begin
        if (((28'(up_cut_reg) < cyc_x100) || wait_hi_reg) && busy_hi_reg)
        begin
            hint_calc = HINT_FAST;
        end
        else if (((cyc_x100 + 28'(HUNDRED)) <= 28'(down_cut_reg)) && (q_head.flev != 4'd0))
        begin
            hint_calc = HINT_SLOW;
        end
        else
        begin
            hint_calc = HINT_NONE;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_nonempty)
                begin
                    state_next = (q_head.kind == JOB_DECIDE) ? B_RATE : B_OUT;
                end
            end
            B_RATE:  state_next = div_rsp.done ? B_CHECK : B_RATE;
            B_CHECK: state_next = (rate_reg > wm_reg) ? B_VOTE : B_CYC;
            B_CYC:   state_next = div_rsp.done ? B_WAIT : B_CYC;
            B_WAIT:
            begin
                if (q_head.ram == '0 || div_rsp.done)
                begin
                    state_next = B_BUSY;
                end
            end
            B_BUSY:  state_next = div_rsp.done ? B_UP : B_BUSY;
            B_UP:    state_next = B_DOWN;
            B_DOWN:  state_next = B_HINT;
            B_HINT:  state_next = B_VOTE;
            B_VOTE:
            begin
                if (bw_reg != '0)
                begin
                    state_next = B_MUL1;
                end
                else if (hint_reg != HINT_NONE)
                begin
                    state_next = B_PCT;
                end
                else
                begin
                    state_next = B_OUT;
                end
            end
            B_MUL1:  state_next = B_MUL2;
            B_MUL2:  state_next = B_MB;
            B_MB:    state_next = B_OUT;
            B_PCT:   state_next = div_rsp.done ? B_OUT : B_PCT;
            B_OUT:   state_next = out_load ? B_IDLE : B_OUT;
            default: state_next = B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        div_state   = 1'b0;
        div_req.num = '0;
        div_req.den = q_head.total;
        out_load    = 1'b0;
        case (state_reg)
            B_RATE:
            begin
                div_state   = 1'b1;
                div_req.num = 40'(q_head.ram);
            end
            B_CYC:
            begin
                div_state   = 1'b1;
                div_req.num = 40'(ram_plus_wait);
            end
            B_WAIT:
            begin
                div_state   = (q_head.ram != '0);
                div_req.num = 40'(q_head.wait_cyc) * 40'(HUNDRED);
                div_req.den = q_head.ram;
            end
            B_BUSY:
            begin
                div_state   = 1'b1;
                div_req.num = 40'(q_head.busy) * 40'(HUNDRED);
            end
            B_PCT:
            begin
                div_state   = 1'b1;
                div_req.num = 40'(rate_reg) * 40'(HUNDRED);
                div_req.den = 32'(abmax_reg);
            end
            B_OUT:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                div_state = 1'b0;
            end
        endcase
    end

    assign div_req.start = div_state && !pend_reg && !div_rsp.done;
    assign q_pop         = out_load;

    // result fields
    assign ab_full   = 44'(abq_reg) * 44'(STEP_MB);
    assign ab_valid  = (q_head.kind == JOB_DECIDE) && (bw_reg != '0);
    assign pct_valid = (q_head.kind == JOB_DECIDE) && (bw_reg == '0) && (hint_reg != HINT_NONE);
    assign ab_mb     = ab_valid ? ab_full[24:0] : '0;

    always_comb
    begin
        wm_next    = wm_reg;
        abmax_next = abmax_reg;
        if (cfg_we && reg_idx_t'(cfg_index) == REG_INIT_WM)
        begin
            wm_next = cfg_data[16:0];
        end
        else if (state_reg == B_CHECK && rate_reg > wm_reg)
        begin
            wm_next = rate_reg;
        end
        if (state_reg == B_VOTE && bw_reg == '0 && hint_reg != HINT_NONE &&
            rate_reg > abmax_reg)
        begin
            abmax_next = rate_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            up_pct_reg    <= '0;
            down_pct_reg  <= '0;
            map_reg       <= '0;
            count_reg     <= 4'd8;
            bw_reg        <= '0;
            wm_reg        <= '0;
            abmax_reg     <= AB_MAX_RESET;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wm_reg    <= wm_next;
            abmax_reg <= abmax_next;
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_UP_PCT:    up_pct_reg   <= cfg_data;
                    REG_DOWN_PCT:  down_pct_reg <= cfg_data;
                    REG_LEVEL_MAP: map_reg      <= cfg_data;
                    REG_LEVEL_CNT: count_reg    <= cfg_data[3:0];
                    REG_BUS_WIDTH: bw_reg       <= cfg_data[7:0];
                    default:       count_reg    <= count_reg;
                endcase
            end
            if (div_req.start)
            begin
                pend_reg <= 1'b1;
            end
            else if (div_rsp.done)
            begin
                pend_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_RATE:
            begin
                if (div_rsp.done)
                begin
                    rate_reg <= div_rsp.quo[16:0];
                end
                wait_hi_reg <= 1'b0;
            end
            B_CHECK:
            begin
                hint_reg <= HINT_FAST;
            end
            B_CYC:
            begin
                if (div_rsp.done)
                begin
                    cyc_reg <= div_rsp.quo[17:0];
                end
            end
            B_WAIT:
            begin
                if (div_rsp.done)
                begin
                    wait_hi_reg <= (div_rsp.quo > 40'(WAIT_LIMIT));
                end
            end
            B_BUSY:
            begin
                if (div_rsp.done)
                begin
                    busy_hi_reg <= (div_rsp.quo > 40'(BUSY_LIMIT));
                end
            end
            B_UP:
            begin
                up_cut_reg <= 25'(up_pct) * 25'(wm_reg);
            end
            B_DOWN:
            begin
                down_cut_reg <= 25'(down_pct) * 25'(wm_reg);
            end
            B_HINT:
            begin
                hint_reg <= hint_calc;
            end
            B_MUL1:
            begin
                prod_reg <= 25'(rate_reg) * 25'(bw_reg);
            end
            B_MUL2:
            begin
                mb_reg <= mb_full[44:20];
            end
            B_MB:
            begin
                abq_reg <= mb_div[RECIP_5_SHIFT +: 18];
            end
            B_PCT:
            begin
                if (div_rsp.done)
                begin
                    pct_reg <= div_rsp.quo[6:0];
                end
            end
            default:
            begin
                hint_reg <= hint_reg;
            end
        endcase
        if (out_load)
        begin
            if (q_head.kind == JOB_DECIDE)
            begin
                out_flags_reg <= {pct_valid, ab_valid, 1'b1};
                out_data_reg  <= {6'b0, (pct_valid ? pct_reg : 7'd0), ab_mb, hint_reg};
            end
            else
            begin
                out_flags_reg <= '0;
                out_data_reg  <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_flags = out_flags_reg;
    assign out_data  = out_data_reg;

    `BBVG_ASSERT_NOW(a_div_start_idle, div_req.start, !div_rsp.busy,
        "divider started while busy")
    `BBVG_ASSERT_NOW(a_pop_nonempty, q_pop, q_nonempty && state_reg == B_OUT,
        "queue popped outside result load")
    `BBVG_ASSERT_NOW(a_pct_den, state_reg == B_PCT, abmax_reg >= rate_reg && abmax_reg != '0,
        "percent divisor below rate")
    `BBVG_ASSERT_NEXT(a_done_leaves, div_rsp.done && div_state, state_reg != $past(state_reg),
        "sequencer held after divider result")

endmodule

FILE: hw/rtl/bus_bandwidth_vote_governor_unit.sv
// Channel  | Direction | Handshake          | Payload
// s_axis   | in        | s_tvalid/s_tready  | tuser: command; tdata: window counters, level
// m_axis   | out       | m_tvalid/m_tready  | tuser: decided, ab_valid, percent_valid
// cfg      | in        | cfg_we             | cfg_index, cfg_data (no read-back)
//
// Front accepts one transaction per cycle, while the queue is not full, into a
// two-entry job queue. A window below the time floor or a suspend passes the
// back end without a division. A decision runs 1 to 5 divisions on one shared
// radix-2 divider; constant divisors use shifts, compares and a reciprocal
// product instead. Reset is asynchronous; no clearing pass. A stalled m_axis
// holds the result register while the front keeps filling the queue.
module bus_bandwidth_vote_governor_unit
    import bbvg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // window_total, window_busy, window_ram, window_wait,
                                   // freq_level, level_offset
    input  logic         s_tuser,  // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,  // hint, ab_megabytes, percent_vote, zero fill
    output logic [2:0]   m_tuser,  // decided, ab_valid, percent_valid
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    logic     q_full, q_push, q_pop, q_nonempty;
    job_t     q_job, q_head;
    div_req_t div_req;
    div_rsp_t div_rsp;

    bbvg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .command  (s_tuser),
        .fields   (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job)
    );

    bbvg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .full     (q_full),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    bbvg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    bbvg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_flags  (m_tuser),
        .out_data   (m_tdata)
    );

endmodule

FILE: tb/tb_bus_bandwidth_vote_governor_unit.sv
`timescale 1ns / 100ps

module tb_bus_bandwidth_vote_governor_unit;
    import bbvg_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;  // window_total, window_busy, window_ram, window_wait,
                            // freq_level, level_offset
    logic         s_tuser;  // command
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;  // hint, ab_megabytes, percent_vote, zero fill
    logic [2:0]   m_tuser;  // decided, ab_valid, percent_valid
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_data;

    bus_bandwidth_vote_governor_unit dut (.*);

    typedef struct {
        logic        decided;
        hint_t       hint;
        logic        ab_valid;
        logic [24:0] ab_mb;
        logic        pct_valid;
        logic [6:0]  pct;
    } vote_t;

    vote_t       votes_pending[$];
    int          error_count = 0;
    int          windows_sent = 0;
    int          decisions_seen = 0;
    int          hints_seen[3] = '{0, 0, 0};
    bit          no_idle = 0;

    // shadow configuration and state
    logic [63:0] up_pct_r, down_pct_r, map_r;
    logic [3:0]  count_r;
    logic [7:0]  width_r;
    logic [16:0] init_wm_r;
    longint unsigned sum_total, sum_busy, sum_ram, sum_wait, wm, rate_max;

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("tb: failure");
        $finish;
    end

    function automatic longint unsigned sat32(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
    endfunction

    function automatic vote_t govern(cmd_t cmd, logic [135:0] d);
        vote_t           v;
        longint unsigned rate, cyc, wpct, bpct, up_cut, down_cut, mb;
        int              flev, cnt, lvl;
        v = '{1'b0, HINT_NONE, 1'b0, 25'd0, 1'b0, 7'd0};
        if (cmd == CMD_SUSPEND)
        begin
            sum_total = 0;
            sum_busy = 0;
            sum_ram = 0;
            return v;
        end
        sum_total = sat32(sum_total, d[31:0]);
        sum_busy  = sat32(sum_busy, d[63:32]);
        sum_ram   = sat32(sum_ram, d[95:64]);
        sum_wait  = sat32(sum_wait, d[127:96]);
        if (sum_total < FLOOR_TIME)
            return v;
        rate = sum_ram / sum_total;
        cyc  = (sum_ram + sum_wait) / sum_total;
        wpct = (sum_ram != 0) ? (100 * sum_wait) / sum_ram : 0;
        bpct = (100 * sum_busy) / sum_total;
        flev = int'(d[131:128]);
        if (rate > wm)
        begin
            wm = rate & 17'h1FFFF;
            v.hint = HINT_FAST;
        end
        else
        begin
            cyc = (100 * cyc) / 80;
            cnt = (count_r < 1) ? 1 : (count_r > BUS_LEVELS) ? BUS_LEVELS : count_r;
            lvl = int'(map_r[flev*4 +: 4]) + int'($signed(d[135:132]));
            if (lvl < 0)
                lvl = 0;
            if (lvl >= cnt)
                lvl = cnt - 1;
            up_cut   = longint'(up_pct_r[lvl*8 +: 8]) * wm / 100;
            down_cut = longint'(down_pct_r[lvl*8 +: 8]) * wm / 100;
            if ((cyc > up_cut || wpct > WAIT_LIMIT) && bpct > BUSY_LIMIT)
                v.hint = HINT_FAST;
            else if (cyc < down_cut && flev != 0)
                v.hint = HINT_SLOW;
        end
        if (width_r != 0)
        begin
            mb = (rate * width_r * 64'd1000000) >> 20;
            v.ab_mb = 25'(((mb + STEP_MB - 1) / STEP_MB) * STEP_MB);
            v.ab_valid = 1;
        end
        else if (v.hint != HINT_NONE)
        begin
            if (rate > rate_max)
                rate_max = rate & 17'h1FFFF;
            v.pct = 7'((100 * rate) / rate_max);
            v.pct_valid = 1;
        end
        sum_total = 0;
        sum_busy = 0;
        sum_ram = 0;
        sum_wait = 0;
        v.decided = 1;
        return v;
    endfunction

    // result checker, also drives the random stall on m_tready
    always @(posedge clk)
    begin
        vote_t v;
        m_tready <= no_idle || ($urandom_range(0, 99) >= 13);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (votes_pending.size() == 0)
            begin
                $error("unexpected result transaction");
                error_count++;
            end
            else
            begin
                v = votes_pending.pop_front();
                if (m_tuser[0] !== v.decided)
                begin
                    $error("decided: expected %0d actual %0d", v.decided, m_tuser[0]);
                    error_count++;
                end
                if (m_tdata[1:0] !== v.hint)
                begin
                    $error("hint: expected %0d actual %0d", v.hint, m_tdata[1:0]);
                    error_count++;
                end
                if (m_tuser[1] !== v.ab_valid)
                begin
                    $error("ab_valid: expected %0d actual %0d", v.ab_valid, m_tuser[1]);
                    error_count++;
                end
                if (m_tdata[26:2] !== v.ab_mb)
                begin
                    $error("ab_megabytes: expected %0d actual %0d", v.ab_mb, m_tdata[26:2]);
                    error_count++;
                end
                if (m_tuser[2] !== v.pct_valid)
                begin
                    $error("percent_valid: expected %0d actual %0d", v.pct_valid, m_tuser[2]);
                    error_count++;
                end
                if (m_tdata[33:27] !== v.pct)
                begin
                    $error("percent_vote: expected %0d actual %0d", v.pct, m_tdata[33:27]);
                    error_count++;
                end
                if (v.decided)
                begin
                    decisions_seen++;
                    hints_seen[v.hint]++;
                end
            end
        end
    end

    task automatic send_window(cmd_t cmd, logic [31:0] tot, logic [31:0] bsy,
                               logic [31:0] ram, logic [31:0] wt, logic [3:0] flev,
                               logic [3:0] off);
        vote_t v;
        if (!no_idle && $urandom_range(0, 99) < 13)
        begin
            s_tvalid <= 0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 13);
        end
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= {off, flev, wt, ram, bsy, tot};
        do
            @(posedge clk);
        while (!s_tready);
        v = govern(cmd, {off, flev, wt, ram, bsy, tot});
        votes_pending.push_back(v);
        windows_sent++;
    endtask

    // drop valid and wait for every outstanding vote before touching registers
    task automatic drain;
        s_tvalid <= 0;
        @(posedge clk);
        while (votes_pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [63:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 0;
        case (idx)
            REG_UP_PCT:    up_pct_r = val;
            REG_DOWN_PCT:  down_pct_r = val;
            REG_LEVEL_MAP: map_r = val;
            REG_LEVEL_CNT: count_r = val[3:0];
            REG_BUS_WIDTH: width_r = val[7:0];
            REG_INIT_WM:
            begin
                init_wm_r = val[16:0];
                wm = val[16:0];
            end
            default: ;
        endcase
    endtask

    task automatic test_directed;
        // below the floor twice, then crossing it with a new watermark
        send_window(CMD_SAMPLE, 32'd20000, 32'd20000, 32'd40000, 32'd0, 4'd0, 4'd0);
        send_window(CMD_SAMPLE, 32'd29999, 32'd0, 32'd0, 32'd0, 4'd0, 4'd0);
        send_window(CMD_SAMPLE, 32'd1, 32'd0, 32'd500000, 32'd9000, 4'd1, 4'd0);
        // zero memory time, rate below the watermark
        send_window(CMD_SAMPLE, 32'd50000, 32'd50000, 32'd0, 32'd777, 4'd3, 4'd0);
        // suspend keeps the wait accumulator
        send_window(CMD_SAMPLE, 32'd100, 32'd5, 32'd6, 32'd50000, 4'd0, 4'd0);
        send_window(CMD_SUSPEND, '1, '1, '1, '1, 4'hF, 4'hF);
        send_window(CMD_SAMPLE, 32'd60000, 32'd59000, 32'd60000, 32'd0, 4'd15, 4'd7);
        // every window counter at its all-ones maximum
        send_window(CMD_SAMPLE, '1, '1, '1, '1, 4'd15, 4'b1000);
        send_window(CMD_SAMPLE, '1, '1, '1, '1, 4'd0, 4'b0111);
        drain();
        write_reg(REG_UP_PCT, 64'hFF00_8040_2010_0500);
        write_reg(REG_DOWN_PCT, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_LEVEL_MAP, 64'hFEDC_BA98_7654_3210);
        write_reg(REG_LEVEL_CNT, 64'd0);
        write_reg(REG_INIT_WM, 64'h1FFFF);
        // unknown indexes must be ignored
        cfg_we <= 1;
        cfg_index <= 3'd6;
        cfg_data <= '1;
        @(posedge clk);
        cfg_index <= 3'd7;
        @(posedge clk);
        cfg_we <= 0;
        send_window(CMD_SAMPLE, 32'd50000, 32'd0, 32'd100000, 32'd0, 4'd5, 4'd0);
        send_window(CMD_SAMPLE, 32'd50000, 32'd50000, 32'd100000, 32'd50000, 4'd5, 4'b1000);
        drain();
        write_reg(REG_LEVEL_CNT, 64'd15);
        write_reg(REG_BUS_WIDTH, 64'd255);
        send_window(CMD_SAMPLE, 32'd50000, 32'd50000, '1, 32'd0, 4'd9, 4'd7);
        send_window(CMD_SAMPLE, 32'd50000, 32'd40000, 32'd50001, 32'd100, 4'd0, 4'd0);
        drain();
        write_reg(REG_BUS_WIDTH, 64'd1);
        write_reg(REG_INIT_WM, 64'd0);
        send_window(CMD_SAMPLE, 32'd50000, 32'd50000, 32'd8000000, 32'd0, 4'd2, 4'd0);
        send_window(CMD_SAMPLE, '1, 32'd0, 32'd0, 32'd0, 4'd2, 4'd0);
        drain();
    endtask

    task automatic test_random_phase(int n, bit quiet);
        longint unsigned tot, ram, span;
        int              sel;
        drain();
        write_reg(REG_UP_PCT, {$urandom, $urandom});
        write_reg(REG_DOWN_PCT, {$urandom, $urandom});
        write_reg(REG_LEVEL_MAP, {$urandom, $urandom});
        write_reg(REG_LEVEL_CNT, 64'($urandom_range(0, 15)));
        write_reg(REG_BUS_WIDTH, 64'(($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 255)));
        write_reg(REG_INIT_WM, 64'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                              : $urandom_range(0, 4000)));
        no_idle = quiet;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
                send_window(CMD_SUSPEND, $urandom, $urandom, $urandom, $urandom,
                            4'($urandom), 4'($urandom));
            else if (sel < 14)
                send_window(CMD_SAMPLE, $urandom, $urandom, $urandom, $urandom,
                            4'($urandom), 4'($urandom));
            else
            begin
                tot = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 49999)
                                                 : $urandom_range(50000, 300000);
                span = wm + wm / 8 + 2;
                ram = tot * $urandom_range(0, 32'(span));
                if (ram > 64'hFFFF_FFFF)
                    ram = 64'hFFFF_FFFF;
                send_window(CMD_SAMPLE, 32'(tot), 32'(tot * $urandom_range(0, 120) / 100),
                            32'(ram), 32'(ram * $urandom_range(0, 30) / 100),
                            4'($urandom), 4'($urandom));
            end
        end
        no_idle = 0;
    endtask

    initial
    begin
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = CMD_SAMPLE;
        m_tready = 0;
        cfg_we = 0;
        cfg_index = REG_UP_PCT;
        cfg_data = '0;
        up_pct_r = 0;
        down_pct_r = 0;
        map_r = 0;
        count_r = 8;
        width_r = 0;
        init_wm_r = 0;
        sum_total = 0;
        sum_busy = 0;
        sum_ram = 0;
        sum_wait = 0;
        wm = 0;
        rate_max = AB_MAX_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        // one phase runs with both sides never idling
        for (int p = 0; p < 6; p++)
            test_random_phase(295, p == 2);
        drain();
        repeat (400) @(posedge clk);
        $display("covered %0d windows, %0d decisions (none %0d, fast %0d, slow %0d)",
                 windows_sent, decisions_seen, hints_seen[0], hints_seen[1], hints_seen[2]);
        if (error_count == 0 && votes_pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/bbvg_pkg.sv
hw/rtl/bbvg_front.sv
hw/rtl/bbvg_queue.sv
hw/rtl/bbvg_div.sv
hw/rtl/bbvg_back.sv
hw/rtl/bus_bandwidth_vote_governor_unit.sv
tb/tb_bus_bandwidth_vote_governor_unit.sv
